// File: src/stream_profile_attributes_assert.svh
// Assertion macros shared by the stream profile checker.
`ifndef STREAM_PROFILE_ATTRIBUTES_ASSERT_SVH
`define STREAM_PROFILE_ATTRIBUTES_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/spa_pkg.sv
// Shared types, constants and helpers of the stream profile attribute block.
package spa_pkg;

  // Cell store geometry
  localparam int MAX_CELLS = 64;
  localparam int CELL_AW   = $clog2(MAX_CELLS);
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int CELL_W    = 96;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // Arithmetic widths
  localparam int VAL_W      = 48;
  localparam int DIV_W      = 64;
  localparam int DIV_STEPS  = 112;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  localparam logic [VAL_W-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 48'h8000_0000_0000;

  // Attribute kinds
  localparam logic [3:0] KIND_ID    = 4'd0;
  localparam logic [3:0] KIND_CUM   = 4'd1;
  localparam logic [3:0] KIND_CELL  = 4'd2;
  localparam logic [3:0] KIND_DIFF  = 4'd3;
  localparam logic [3:0] KIND_DROP  = 4'd4;
  localparam logic [3:0] KIND_GRAD  = 4'd5;
  localparam logic [3:0] KIND_LGRAD = 4'd6;
  localparam logic [3:0] KIND_LDIST = 4'd7;
  localparam logic [3:0] KIND_CURV  = 4'd8;

  // Register indexes
  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_ORDER = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  // Dividend pre-shift of the divider
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_48 = 2'd2
  } shift_t;

  // One emission command: which cell, and what the front already knows
  typedef struct packed {
    logic [CELL_AW-1:0] j;
    logic [CELL_AW-1:0] ref_j;
    logic [CELL_AW-1:0] ordinal;
    logic [15:0]        stream;
    logic               first;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] addr;
    logic [CELL_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] a;
    shift_t           sh;
    logic [DIV_W-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  // Signed, saturated Q32.16 value from a magnitude and a sign
  function automatic logic [VAL_W-1:0] from_mag(input logic [DIV_W-1:0] mag, input logic neg);
    logic [VAL_W-1:0] res;
    if (neg) begin
      res = (mag >= {16'b0, VAL_MIN}) ? VAL_MIN : (~mag[VAL_W-1:0] + 48'd1);
    end else begin
      res = (mag > {16'b0, VAL_MAX}) ? VAL_MAX : mag[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: src/spa_ram.sv
// Generic simple dual-port RAM with registered read.
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/spa_fifo.sv
// Short command queue between the front and back parts.
module spa_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spa_pkg::cmd_t din,
  input  logic          pop,
  output spa_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import spa_pkg::*;

  cmd_t            slots [QUEUE_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (Q_AW+1)'(QUEUE_DEPTH));
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/spa_div.sv
// Radix-2 restoring divider: floor(a * 2^k / b), saturating at 2^64-1.
module spa_div (
  input  logic              clk,
  input  logic              rst,
  input  spa_pkg::div_req_t req,
  output spa_pkg::div_rsp_t rsp
);
  import spa_pkg::*;

  logic [DIV_STEPS-1:0] num;
  logic [DIV_W-1:0]     den;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic                 sat;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_W:0] rem_sh;
  logic           ge;
  logic [DIV_W:0] rem_nx;

  // One quotient bit per cycle
  assign rem_sh = {rem, num[DIV_STEPS-1]};
  assign ge     = (rem_sh >= {1'b0, den});
  assign rem_nx = ge ? (rem_sh - {1'b0, den}) : rem_sh;

  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.sh)
        SH_0:    num <= {48'b0, req.a};
        SH_16:   num <= {32'b0, req.a, 16'b0};
        SH_48:   num <= {req.a, 48'b0};
        default: num <= {48'b0, req.a};
      endcase
      den <= req.b;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      num <= {num[DIV_STEPS-2:0], 1'b0};
      rem <= rem_nx[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
      sat <= sat | quo[DIV_W-1];
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = sat ? '1 : quo;
  assign rsp.rem  = rem;

endmodule

// File: src/spa_sqrt.sv
// Bit-pair integer square root of a 64-bit word, one step per cycle.
module spa_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  spa_pkg::sqrt_req_t req,
  output spa_pkg::sqrt_rsp_t rsp
);
  import spa_pkg::*;

  logic [63:0]           x;
  logic [63:0]           res;
  logic [63:0]           bt;
  logic [SQRT_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;
  logic [63:0]           trial;
  logic                  ge;

  assign trial = res + bt;
  assign ge    = (x >= trial);

  always_ff @(posedge clk) begin
    if (req.start) begin
      x   <= req.x;
      res <= '0;
      bt  <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (ge) begin
        x   <= x - trial;
        res <= (res >> 1) + bt;
      end else begin
        res <= res >> 1;
      end
      bt <= bt >> 2;
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[31:0];

endmodule

// File: src/spa_front.sv
// Front part: loads cells into the store and issues one command per interior cell.
module spa_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cell_valid,
  output logic               cell_stall,
  input  logic [31:0]        cell_position,
  input  logic signed [31:0] elevation,
  input  logic [31:0]        step_distance,
  input  logic [15:0]        stream_id,
  input  logic               last_cell,
  input  logic [3:0]         kind,
  input  logic               ds,
  input  logic               drained,
  output spa_pkg::ram_wr_t   ram_wr,
  output logic               push,
  output spa_pkg::cmd_t      cmd,
  input  logic               full
);
  import spa_pkg::*;

  typedef enum logic [1:0] {
    F_LOAD = 2'b01,
    F_EMIT = 2'b10
  } front_state_t;

  front_state_t       state;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   n;
  logic [CELL_AW-1:0] k;
  logic [15:0]        stream;

  logic             accept;
  logic [CNT_W-1:0] n_new;
  logic             rev;
  logic [CNT_W-1:0] k_ext;
  logic [CNT_W-1:0] j_ext;
  logic [CNT_W-1:0] ord_ext;
  logic [CNT_W-1:0] ref_ext;

  // New cells only while loading and once the back has finished the last stream
  assign cell_stall = !((state == F_LOAD) && drained);
  assign accept     = cell_valid && !cell_stall;
  assign n_new      = (cnt < CNT_W'(MAX_CELLS)) ? (cnt + 1'b1) : cnt;

  assign ram_wr.we   = accept && (cnt < CNT_W'(MAX_CELLS));
  assign ram_wr.addr = cnt[CELL_AW-1:0];
  assign ram_wr.data = {step_distance, elevation, cell_position};

  // Classify: walk direction, ordinal and drop reference per cell
  assign rev     = ds && (kind inside {KIND_CUM, KIND_DROP, KIND_GRAD});
  assign k_ext   = {1'b0, k};
  assign j_ext   = rev ? (n - CNT_W'(2) - k_ext) : (k_ext + CNT_W'(1));
  assign ord_ext = ds ? (n - CNT_W'(1) - j_ext) : j_ext;
  assign ref_ext = ds ? (n - CNT_W'(2)) : CNT_W'(1);

  assign cmd.j       = j_ext[CELL_AW-1:0];
  assign cmd.ordinal = ord_ext[CELL_AW-1:0];
  assign cmd.ref_j   = ref_ext[CELL_AW-1:0];
  assign cmd.stream  = stream;
  assign cmd.first   = (k == '0);
  assign cmd.last    = (k_ext == (n - CNT_W'(3)));
  assign push        = (state == F_EMIT) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_LOAD;
      cnt    <= '0;
      n      <= '0;
      k      <= '0;
      stream <= '0;
    end else begin
      case (state)
        F_LOAD: begin
          if (accept) begin
            cnt    <= n_new;
            stream <= stream_id;
            if (last_cell) begin
              if (n_new >= CNT_W'(3)) begin
                n     <= n_new;
                k     <= '0;
                state <= F_EMIT;
              end else begin
                cnt <= '0;
              end
            end
          end
        end
        F_EMIT: begin
          if (push) begin
            k <= k + 1'b1;
            if (cmd.last) begin
              cnt   <= '0;
              state <= F_LOAD;
            end
          end
        end
        default: state <= F_LOAD;
      endcase
    end
  end

endmodule

// File: src/spa_back.sv
// Back part: reads a cell's neighborhood, computes its attribute, holds the result.
module spa_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          kind,
  input  logic                ds,
  input  logic [15:0]         cols,
  input  spa_pkg::cmd_t       head,
  input  logic                empty,
  output logic                pop,
  output logic [spa_pkg::CELL_AW-1:0] raddr,
  input  logic [spa_pkg::CELL_W-1:0]  rdata,
  output spa_pkg::div_req_t   div_req,
  input  spa_pkg::div_rsp_t   div_rsp,
  output spa_pkg::sqrt_req_t  sqrt_req,
  input  spa_pkg::sqrt_rsp_t  sqrt_rsp,
  output logic                busy,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [15:0]         row,
  output logic [15:0]         column,
  output logic signed [47:0]  value,
  output logic                divide_fault,
  output logic                last_result
);
  import spa_pkg::*;

  typedef enum logic [16:0] {
    B_IDLE = 17'h00001,
    B_RD0  = 17'h00002,
    B_RD1  = 17'h00004,
    B_RD2  = 17'h00008,
    B_RD3  = 17'h00010,
    B_RD4  = 17'h00020,
    B_RC   = 17'h00040,
    B_CALC = 17'h00080,
    B_QDIV = 17'h00100,
    B_CF   = 17'h00200,
    B_CS   = 17'h00400,
    B_MUL  = 17'h00800,
    B_QSUM = 17'h01000,
    B_SQRT = 17'h02000,
    B_CT   = 17'h04000,
    B_CU   = 17'h08000,
    B_OUT  = 17'h10000
  } back_state_t;

  back_state_t state;
  cmd_t        cur;

  logic [31:0]        pos_j;
  logic signed [31:0] e_jm1;
  logic signed [31:0] e_j;
  logic signed [31:0] e_jp1;
  logic signed [31:0] e_ref;
  logic [31:0]        d_jm1;
  logic [31:0]        d_j;
  logic [15:0]        row_r;
  logic [15:0]        col_r;
  logic [VAL_W-1:0]   rl;
  logic [VAL_W-1:0]   val;
  logic               fault;
  logic               neg;
  logic [DIV_W-1:0]   den_r;
  logic [VAL_W-1:0]   f_mag;
  logic               f_neg;
  logic [VAL_W-1:0]   sm;
  logic [63:0]        s2;
  logic               big;
  logic [63:0]        q;
  logic [31:0]        r_root;

  // Neighborhood arithmetic
  logic [32:0]      diff_fwd;
  logic [32:0]      diff_bwd;
  logic [32:0]      drop;
  logic [32:0]      lgrad_num;
  logic [32:0]      q_num;
  logic [32:0]      q_mag;
  logic [VAL_W-1:0] q_den;
  logic [VAL_W-1:0] rl_base;
  logic [VAL_W-1:0] rl_new;
  logic [32:0]      den_c;
  logic [32:0]      f_num;
  logic [32:0]      f_abs;
  logic [33:0]      s_num;
  logic [33:0]      s_abs;
  logic [VAL_W-1:0] f_val;
  logic [VAL_W-1:0] s_val;
  logic [64:0]      sum65;

  assign diff_fwd  = {e_j[31], e_j} - {e_jp1[31], e_jp1};
  assign diff_bwd  = {e_jm1[31], e_jm1} - {e_j[31], e_j};
  assign drop      = ds ? ({e_j[31], e_j} - {e_ref[31], e_ref})
                        : ({e_ref[31], e_ref} - {e_j[31], e_j});
  assign lgrad_num = diff_fwd[32] ? '0 : diff_fwd;
  assign rl_base   = cur.first ? '0 : rl;
  assign rl_new    = rl_base + {16'b0, d_j};
  assign q_num     = (kind == KIND_GRAD) ? drop : lgrad_num;
  assign q_mag     = q_num[32] ? (~q_num + 33'd1) : q_num;
  assign q_den     = (kind == KIND_GRAD) ? rl_new : {16'b0, d_j};
  assign den_c     = {1'b0, d_jm1} + {1'b0, d_j};
  assign f_num     = {e_jm1[31], e_jm1} - {e_jp1[31], e_jp1};
  assign f_abs     = f_num[32] ? (~f_num + 33'd1) : f_num;
  assign s_num     = {{2{e_jm1[31]}}, e_jm1} - {e_j[31], e_j, 1'b0} + {{2{e_jp1[31]}}, e_jp1};
  assign s_abs     = s_num[33] ? (~s_num + 34'd1) : s_num;
  assign f_val     = from_mag(div_rsp.quo, neg);
  assign s_val     = from_mag(div_rsp.quo, neg);
  assign sum65     = {1'b0, s2} + 65'h1_0000_0000;

  assign busy = (state != B_IDLE);
  assign pop  = (state == B_IDLE) && !empty;

  // Store read address: cell, left, right, drop reference
  always_comb begin
    case (state)
      B_RD1:   raddr = cur.j - 1'b1;
      B_RD2:   raddr = cur.j + 1'b1;
      B_RD3:   raddr = cur.ref_j;
      default: raddr = cur.j;
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      rl             <= '0;
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            cur   <= head;
            state <= B_RD0;
          end
        end
        B_RD0: state <= B_RD1;
        B_RD1: begin
          pos_j <= rdata[31:0];
          e_j   <= rdata[63:32];
          d_j   <= rdata[95:64];
          state <= B_RD2;
        end
        B_RD2: begin
          e_jm1 <= rdata[63:32];
          d_jm1 <= rdata[95:64];
          state <= B_RD3;
        end
        B_RD3: begin
          e_jp1 <= rdata[63:32];
          state <= B_RD4;
        end
        B_RD4: begin
          e_ref         <= rdata[63:32];
          div_req.start <= 1'b1;
          div_req.a     <= {32'b0, pos_j};
          div_req.sh    <= SH_0;
          div_req.b     <= {48'b0, cols};
          state         <= B_RC;
        end
        B_RC: begin
          if (div_rsp.done) begin
            row_r <= div_rsp.quo[15:0];
            col_r <= div_rsp.rem[15:0];
            state <= B_CALC;
          end
        end
        B_CALC: begin
          fault <= 1'b0;
          state <= B_OUT;
          case (kind)
            KIND_ID:    val <= {16'b0, cur.stream, 16'b0};
            KIND_CUM: begin
              rl  <= rl_new;
              val <= from_mag({16'b0, rl_new}, 1'b0);
            end
            KIND_CELL:  val <= {26'b0, cur.ordinal, 16'b0};
            KIND_DIFF: begin
              val <= ds ? {{15{diff_bwd[32]}}, diff_bwd} : {{15{diff_fwd[32]}}, diff_fwd};
            end
            KIND_DROP:  val <= {{15{drop[32]}}, drop};
            KIND_GRAD, KIND_LGRAD: begin
              if (kind == KIND_GRAD) begin
                rl <= rl_new;
              end
              if (q_den == '0) begin
                // zero divisor: saturate by the numerator's sign
                fault <= 1'b1;
                val   <= q_num[32] ? VAL_MIN : VAL_MAX;
              end else begin
                neg           <= q_num[32];
                div_req.start <= 1'b1;
                div_req.a     <= {31'b0, q_mag};
                div_req.sh    <= SH_16;
                div_req.b     <= {16'b0, q_den};
                state         <= B_QDIV;
              end
            end
            KIND_LDIST: val <= {16'b0, d_j};
            KIND_CURV: begin
              if (den_c == '0) begin
                fault <= 1'b1;
                val   <= f_num[32] ? VAL_MIN : VAL_MAX;
              end else begin
                neg           <= f_num[32];
                den_r         <= {31'b0, den_c};
                div_req.start <= 1'b1;
                div_req.a     <= {31'b0, f_abs};
                div_req.sh    <= SH_16;
                div_req.b     <= {31'b0, den_c};
                state         <= B_CF;
              end
            end
            default:    val <= '0;
          endcase
        end
        B_QDIV: begin
          if (div_rsp.done) begin
            val   <= from_mag(div_rsp.quo, neg);
            state <= B_OUT;
          end
        end
        // curvature: slope f
        B_CF: begin
          if (div_rsp.done) begin
            f_neg         <= f_val[VAL_W-1];
            f_mag         <= f_val[VAL_W-1] ? (~f_val + 48'd1) : f_val;
            neg           <= s_num[33];
            div_req.start <= 1'b1;
            div_req.a     <= {30'b0, s_abs};
            div_req.sh    <= SH_16;
            div_req.b     <= den_r;
            state         <= B_CS;
          end
        end
        // curvature: second difference s
        B_CS: begin
          if (div_rsp.done) begin
            sm    <= s_val[VAL_W-1] ? (~s_val + 48'd1) : s_val;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          s2    <= sm[31:0] * sm[31:0];
          big   <= |sm[VAL_W-1:32];
          state <= B_QSUM;
        end
        // q = 1 + s^2 in Q32.32, saturated
        B_QSUM: begin
          q               <= (big || sum65[64]) ? '1 : sum65[63:0];
          sqrt_req.start  <= 1'b1;
          sqrt_req.x      <= (big || sum65[64]) ? '1 : sum65[63:0];
          state           <= B_SQRT;
        end
        B_SQRT: begin
          if (sqrt_rsp.done) begin
            r_root        <= sqrt_rsp.root;
            div_req.start <= 1'b1;
            div_req.a     <= {16'b0, f_mag};
            div_req.sh    <= SH_48;
            div_req.b     <= q;
            state         <= B_CT;
          end
        end
        B_CT: begin
          if (div_rsp.done) begin
            div_req.start <= 1'b1;
            div_req.a     <= div_rsp.quo;
            div_req.sh    <= SH_0;
            div_req.b     <= {32'b0, r_root};
            state         <= B_CU;
          end
        end
        B_CU: begin
          if (div_rsp.done) begin
            val   <= from_mag(div_rsp.quo, f_neg);
            state <= B_OUT;
          end
        end
        // hand the result to the output register
        B_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            row          <= row_r;
            column       <= col_r;
            value        <= $signed(val);
            divide_fault <= fault;
            last_result  <= cur.last;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: src/stream_profile_attributes.sv
// Top level of the stream profile attribute block: registers, store and part wiring.
//
//   channel  direction  handshake              payload
//   cell     in         cell_valid/cell_stall  cell_position elevation step_distance
//                                              stream_id last_cell
//   result   out        result_valid/stall     row column value divide_fault last_result
//   config   in         APB psel/penable       paddr pwdata prdata pready
//
// Cells load one per cycle while cell_stall is low. After the last cell, each interior
// cell takes store reads plus one 112-step division for row and column, one more
// division for gradient kinds, and four divisions plus a 32-step square root for
// curvature, all on the shared divider.
// cell_stall stays high until every result of the current stream has been handed
// to the output register. No clearing pass after reset; the stores need none.
module stream_profile_attributes (
  input  logic               clk,
  input  logic               rst,
  input  logic               cell_valid,
  output logic               cell_stall,
  input  logic [31:0]        cell_position,
  input  logic signed [31:0] elevation,
  input  logic [31:0]        step_distance,
  input  logic [15:0]        stream_id,
  input  logic               last_cell,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [15:0]        row,
  output logic [15:0]        column,
  output logic signed [47:0] value,
  output logic               divide_fault,
  output logic               last_result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import spa_pkg::*;

  logic [3:0]  attribute_kind;
  logic        downstream_order;
  logic [15:0] column_count;
  logic [15:0] cols_eff;

  ram_wr_t            ram_wr;
  logic [CELL_AW-1:0] raddr;
  logic [CELL_W-1:0]  rdata;
  cmd_t               cmd_in;
  cmd_t               cmd_head;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  logic               back_busy;
  logic               drained;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  sqrt_req_t          sqrt_req;
  sqrt_rsp_t          sqrt_rsp;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_kind   <= KIND_CUM;
      downstream_order <= 1'b0;
      column_count     <= 16'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_KIND:  attribute_kind   <= pwdata[3:0];
        REG_ORDER: downstream_order <= pwdata[0];
        REG_COLS:  column_count     <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KIND:  prdata = {28'b0, attribute_kind};
      REG_ORDER: prdata = {31'b0, downstream_order};
      REG_COLS:  prdata = {16'b0, column_count};
      default:   prdata = '0;
    endcase
  end

  // A zero column count splits as one column
  assign cols_eff = (column_count == '0) ? 16'd1 : column_count;
  assign drained  = q_empty && !back_busy;

  spa_ram #(
    .WIDTH(CELL_W),
    .DEPTH(MAX_CELLS)
  ) u_store (
    .clk  (clk),
    .we   (ram_wr.we),
    .waddr(ram_wr.addr),
    .wdata(ram_wr.data),
    .raddr(raddr),
    .rdata(rdata)
  );

  spa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_position(cell_position),
    .elevation    (elevation),
    .step_distance(step_distance),
    .stream_id    (stream_id),
    .last_cell    (last_cell),
    .kind         (attribute_kind),
    .ds           (downstream_order),
    .drained      (drained),
    .ram_wr       (ram_wr),
    .push         (push),
    .cmd          (cmd_in),
    .full         (q_full)
  );

  spa_fifo u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .pop  (pop),
    .head (cmd_head),
    .empty(q_empty),
    .full (q_full)
  );

  spa_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  spa_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .req(sqrt_req),
    .rsp(sqrt_rsp)
  );

  spa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .kind        (attribute_kind),
    .ds          (downstream_order),
    .cols        (cols_eff),
    .head        (cmd_head),
    .empty       (q_empty),
    .pop         (pop),
    .raddr       (raddr),
    .rdata       (rdata),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .sqrt_req    (sqrt_req),
    .sqrt_rsp    (sqrt_rsp),
    .busy        (back_busy),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .row         (row),
    .column      (column),
    .value       (value),
    .divide_fault(divide_fault),
    .last_result (last_result)
  );

endmodule

// File: src/spa_checker.sv
// Port-level checker of the stream profile attribute block and its bind.
`include "stream_profile_attributes_assert.svh"

module spa_checker (
  input logic               clk,
  input logic               rst,
  input logic               cell_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic [15:0]        row,
  input logic [15:0]        column,
  input logic signed [47:0] value,
  input logic               divide_fault,
  input logic               last_result
);
  import spa_pkg::*;

  // a stalled result transaction keeps its payload
  `SPA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(row) && $stable(column) && $stable(value) && $stable(last_result), "stalled result changed")

  // while a stream still has results to come, no new cell is taken
  `SPA_ASSERT_SAME(a_no_load_mid_stream, result_valid && !last_result, cell_stall, "cell taken before stream finished")

  // a zero divisor always comes with a saturated value
  `SPA_ASSERT_SAME(a_fault_saturates, result_valid && divide_fault, ($unsigned(value) == VAL_MAX) || ($unsigned(value) == VAL_MIN), "fault without saturation")

endmodule

bind stream_profile_attributes spa_checker u_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the stream profile attribute block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spa_pkg::*;

  localparam logic [63:0] Q_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VMAX64 = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] VMIN64 = -64'sh8000_0000_0000;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] elev;
    logic [31:0] sdist;
    logic [15:0] sid;
    logic        last;
  } cell_t;

  typedef struct {
    logic [15:0] row;
    logic [15:0] col;
    logic [47:0] val;
    logic        fault;
    logic        last;
  } attr_t;

  logic clk = 0, rst = 1;
  logic cell_valid = 0, cell_stall;
  logic [31:0] cell_position = 0, step_distance = 0;
  logic signed [31:0] elevation = 0;
  logic [15:0] stream_id = 0;
  logic last_cell = 0;
  logic result_valid, result_stall = 0;
  logic [15:0] row, column;
  logic signed [47:0] value;
  logic divide_fault, last_result;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  stream_profile_attributes dut (.*);

  always #5 clk = ~clk;

  // Predictor state and configuration
  logic [31:0] pos_mem [MAX_CELLS];
  logic [31:0] elev_mem [MAX_CELLS];
  logic [31:0] dist_mem [MAX_CELLS];
  int unsigned n_cells;
  logic [15:0] cur_stream;
  logic [3:0] kind_reg = KIND_CUM;
  logic order_reg = 0;
  logic [15:0] cols_reg = 1;

  cell_t pending[$];
  attr_t expected[$];
  int errors = 0;
  bit hold = 0;
  int gap = 0, burst = 0;

  function automatic logic signed [63:0] elev_of(int unsigned j);
    return 64'(signed'(elev_mem[j]));
  endfunction

  // floor(a * 2^k / b), saturating at all ones
  function automatic logic [63:0] div_scaled(logic [63:0] a, int k, logic [63:0] b);
    logic [127:0] num;
    logic [127:0] q;
    num = {64'd0, a} << k;
    q = num / {64'd0, b};
    return (q[127:64] != 0) ? Q_ONES : q[63:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = 128'(r | (64'd1 << b));
      if (t * t <= {64'd0, x}) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_mag(logic [63:0] m, logic neg);
    if (neg) return (m >= 64'h8000_0000_0000) ? VMIN64 : -$signed(m);
    return (m > 64'h7FFF_FFFF_FFFF) ? VMAX64 : $signed(m);
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] ratio(logic signed [63:0] num, logic [63:0] den,
                                                inout logic fault);
    if (den == 0) begin
      fault = 1;
      return num < 0 ? VMIN64 : VMAX64;
    end
    return sat_mag(div_scaled(abs64(num), 16, den), num < 0);
  endfunction

  function automatic logic signed [63:0] curve_at(int unsigned j, inout logic fault);
    logic signed [63:0] a, b, c, f, s;
    logic [63:0] den, sm, q, r, t;
    a = elev_of(j - 1); b = elev_of(j); c = elev_of(j + 1);
    den = 64'(dist_mem[j - 1]) + 64'(dist_mem[j]);
    if (den == 0) begin
      fault = 1;
      return (a - c) < 0 ? VMIN64 : VMAX64;
    end
    f = ratio(a - c, den, fault);
    s = ratio(a - 2 * b + c, den, fault);
    sm = abs64(s);
    if (sm >= 64'h1_0000_0000) q = Q_ONES;
    else q = (sm * sm > Q_ONES - 64'h1_0000_0000) ? Q_ONES : sm * sm + 64'h1_0000_0000;
    r = root64(q);
    t = div_scaled(abs64(f), 48, q);
    return sat_mag(t / r, f < 0);
  endfunction

  // Absorb one cell; on the last cell queue the profile results
  task automatic profile_cell(cell_t c);
    int unsigned cnt, j, cols;
    logic [47:0] run_len;
    logic rev;
    logic signed [63:0] v;
    attr_t o;
    if (n_cells < MAX_CELLS) begin
      pos_mem[n_cells] = c.pos; elev_mem[n_cells] = c.elev; dist_mem[n_cells] = c.sdist;
      n_cells++;
    end
    cur_stream = c.sid;
    if (!c.last) return;
    cnt = n_cells >= 3 ? n_cells - 2 : 0;
    rev = order_reg && (kind_reg == KIND_CUM || kind_reg == KIND_DROP || kind_reg == KIND_GRAD);
    cols = cols_reg ? cols_reg : 1;
    run_len = 0;
    for (int unsigned k = 0; k < cnt; k++) begin
      j = rev ? n_cells - 2 - k : 1 + k;
      o.fault = 0;
      case (kind_reg)
        KIND_ID: v = 64'(cur_stream) << 16;
        KIND_CUM: begin
          run_len = run_len + 48'(dist_mem[j]);
          v = sat_mag(64'(run_len), 0);
        end
        KIND_CELL: v = 64'(order_reg ? n_cells - 1 - j : j) << 16;
        KIND_DIFF: v = order_reg ? elev_of(j - 1) - elev_of(j) : elev_of(j) - elev_of(j + 1);
        KIND_DROP: v = order_reg ? elev_of(j) - elev_of(n_cells - 2) : elev_of(1) - elev_of(j);
        KIND_GRAD: begin
          run_len = run_len + 48'(dist_mem[j]);
          v = ratio(order_reg ? elev_of(j) - elev_of(n_cells - 2) : elev_of(1) - elev_of(j),
                    64'(run_len), o.fault);
        end
        KIND_LGRAD: begin
          v = elev_of(j) - elev_of(j + 1);
          if (v < 0) v = 0;
          v = ratio(v, 64'(dist_mem[j]), o.fault);
        end
        KIND_LDIST: v = 64'(dist_mem[j]);
        KIND_CURV: v = curve_at(j, o.fault);
        default: v = 0;
      endcase
      o.row = 16'(pos_mem[j] / cols);
      o.col = 16'(pos_mem[j] % cols);
      o.val = v[47:0];
      o.last = (k + 1 == cnt);
      expected.push_back(o);
    end
    n_cells = 0;
  endtask

  // Driver: bursts and gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (cell_valid && !cell_stall) profile_cell('{cell_position, elevation, step_distance,
                                                    stream_id, last_cell});
      if (cell_valid && cell_stall) begin
      end else if (gap > 0 || hold || pending.size() == 0) begin
        cell_valid <= 0;
        if (gap > 0) gap <= gap - 1;
      end else begin
        cell_t c;
        c = pending.pop_front();
        cell_valid <= 1;
        cell_position <= c.pos; elevation <= c.elev; step_distance <= c.sdist;
        stream_id <= c.sid; last_cell <= c.last;
        if (burst <= 0) begin
          burst <= $urandom_range(12, 1);
          gap <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else burst <= burst - 1;
      end
    end
  end

  // Monitor and receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        attr_t e;
        if (expected.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d value %h", $time, row, column, value);
          errors++;
        end else begin
          e = expected.pop_front();
          if ({e.row, e.col, e.val, e.fault, e.last} !==
              {row, column, value, divide_fault, last_result}) begin
            $display("%0t: mismatch expected row %0d col %0d value %h fault %b last %b",
                     $time, e.row, e.col, e.val, e.fault, e.last);
            $display("%0t:          actual row %0d col %0d value %h fault %b last %b",
                     $time, row, column, value, divide_fault, last_result);
            errors++;
          end
        end
      end
      if ($urandom_range(200, 0) == 0) stall_mode <= $urandom_range(2, 0);
      case (stall_mode)
        0: result_stall <= 0;
        1: result_stall <= ($urandom_range(3, 0) == 0);
        default: result_stall <= ($urandom_range(3, 0) != 0);
      endcase
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_KIND: kind_reg = data[3:0];
      REG_ORDER: order_reg = data[0];
      default: cols_reg = data[15:0];
    endcase
  endtask

  task automatic drain();
    while (pending.size() != 0 || cell_valid || expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random stream: mostly small elevations and distances, some extremes
  task automatic add_stream(int len, bit wild);
    cell_t c;
    logic [15:0] sid;
    sid = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      c.pos = wild ? $urandom : $urandom_range(5000, 0);
      c.elev = wild ? $urandom : 32'($signed($urandom_range(8000, 0)) - 4000) <<< 8;
      c.sdist = wild ? $urandom : (($urandom_range(7, 0) == 0) ? 0 : $urandom_range(4096, 1) << 4);
      c.sid = ($urandom_range(5, 0) == 0) ? 16'($urandom) : sid;
      c.last = (i == len - 1);
      pending.push_back(c);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(20, 0);
    if (r == 0) return $urandom_range(70, 60);
    if (r < 3) return $urandom_range(2, 1);
    return $urandom_range(9, 3);
  endfunction

  initial begin
    cell_t c;
    int sent;
    repeat (4) @(posedge clk);
    rst <= 0;
    // Directed: extremes, short stream, zero divisors, steep curvature
    apb_write(REG_KIND, KIND_LDIST);
    apb_write(REG_ORDER, 0);
    apb_write(REG_COLS, 0);
    pending.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0});
    pending.push_back('{32'h0, 32'h8000_0000, 32'h0, 16'h0, 1'b0});
    pending.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0});
    pending.push_back('{32'h1234, 32'h0, 32'h0, 16'h5, 1'b1});
    pending.push_back('{32'h1, 32'h1, 32'h1, 16'h1, 1'b0});
    pending.push_back('{32'h2, 32'h2, 32'h2, 16'h1, 1'b1});
    for (int i = 0; i < 6; i++)
      pending.push_back('{32'(i * 7), 32'((i % 2) ? 32'h7FFF_0000 : 32'h8000_0000),
                         32'(i == 2 ? 0 : 16), 16'h3, 1'(i == 5)});
    drain();
    for (int kd = 0; kd <= 9; kd++) begin
      apb_write(REG_KIND, kd == 9 ? 32'd15 : kd);
      apb_write(REG_ORDER, kd % 2);
      apb_write(REG_COLS, kd == 3 ? 32'hFFFF : $urandom_range(300, 1));
      for (int i = 0; i < 4; i++)
        pending.push_back('{32'($urandom), 32'((i == 1) ? 32'h7FFF_FFFF : $urandom),
                           32'((i == 2) ? 0 : $urandom_range(3, 0) << 14), 16'($urandom),
                           1'(i == 3)});
      drain();
    end
    // Random phases over all settings
    sent = 0;
    while (sent < 310) begin
      apb_write(REG_KIND, ($urandom_range(9, 0) == 0) ? $urandom_range(15, 9)
                                                    : $urandom_range(8, 0));
      apb_write(REG_ORDER, $urandom_range(1, 0));
      apb_write(REG_COLS, ($urandom_range(5, 0) == 0) ? 32'hFFFF : $urandom_range(1000, 0));
      for (int s = 0; s < 4; s++) begin
        int len;
        len = pick_len();
        add_stream(len, $urandom_range(4, 0) == 0);
        sent += len;
      end
      if ($urandom_range(3, 0) == 0) begin
        // hold off until all results are back
        hold = 1;
        while (cell_valid || expected.size() != 0) @(posedge clk);
        repeat ($urandom_range(20, 1)) @(posedge clk);
        hold = 0;
      end
      drain();
    end
    if (errors == 0 && expected.size() == 0) begin
      $display("stream_profile_attributes regression: pass");
    end else begin
      $display("stream_profile_attributes regression: fail");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("stream_profile_attributes regression: fail");
    $finish;
  end
endmodule
